FILE: rtl/tsfl_pkg.sv
// shared types and constants for the triangle strip/fan to list assembler
`default_nettype none

package tsfl_pkg;

  // topology codes held in the mode register
  localparam logic [1:0] MODE_LIST   = 2'd0;
  localparam logic [1:0] MODE_STRIP  = 2'd1;
  localparam logic [1:0] MODE_FAN    = 2'd2;
  // spare code, assembles as a list
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // configuration port layout: register i at byte address 4*i
  localparam int ADDR_W = 3;
  localparam logic REG_PRIM_MODE   = 1'b0;
  localparam logic REG_BASE_VERTEX = 1'b1;

  localparam int IDX_W = 16;

  typedef logic [IDX_W-1:0] idx_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [1:0] prim_mode;
    idx_t       base_vertex;
  } cfg_t;

  // rebased index waiting in the input register
  typedef struct packed {
    logic valid;
    idx_t index;
    logic last;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/tsfl_regs.sv
// configuration registers behind the APB-style port
`default_nettype none

module tsfl_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tsfl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output tsfl_pkg::cfg_t                  cfg
);
  import tsfl_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes, decoded on the word address
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prim_mode   <= MODE_LIST;
      cfg.base_vertex <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_PRIM_MODE:   cfg.prim_mode   <= pwdata[1:0];
        REG_BASE_VERTEX: cfg.base_vertex <= pwdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[2])
      REG_PRIM_MODE:   prdata = {30'd0, cfg.prim_mode};
      REG_BASE_VERTEX: prdata = {{(32-IDX_W){1'b0}}, cfg.base_vertex};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/tsfl_in_stage.sv
// input register: takes one index request and rebases it
`default_nettype none

module tsfl_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [15:0]     s_tdata,   // [15:0] vertex_index
  input  wire logic            s_tlast,   // last_index
  input  wire tsfl_pkg::idx_t  base_vertex,
  input  wire logic            advance,
  output tsfl_pkg::item_t      item
);
  import tsfl_pkg::*;

  // free when empty or when the held item moves on this cycle
  assign s_tready = !item.valid || advance;

  // valid flag, plus payload: rebased index, wraps modulo 2^16
  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item.valid <= 1'b1;
    end else if (advance) begin
      item.valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      item.index <= s_tdata[IDX_W-1:0] + base_vertex;
      item.last  <= s_tlast;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tsfl_assemble.sv
// assembly state and triangle result register
`default_nettype none

module tsfl_assemble (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tsfl_pkg::item_t item,
  input  wire logic [1:0]      prim_mode,
  output logic                 advance,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [47:0]          m_tdata,   // [15:0] corner_a, [31:16] corner_b, [47:32] corner_c
  output logic                 m_tlast    // final_triangle
);
  import tsfl_pkg::*;

  idx_t       fan_anchor, older_index, newer_index;
  logic [1:0] fill_count;
  logic       odd_triangle;

  idx_t       fan_anchor_next, older_index_next, newer_index_next;
  logic [1:0] fill_count_next;
  logic       odd_triangle_next;
  logic       emit;
  idx_t       tri_a, tri_b, tri_c;

  // item moves on when the result register can take its request
  assign advance = item.valid && (!m_tvalid || m_tready);

  // next state and triangle for the held index
  always_comb begin
    fan_anchor_next   = fan_anchor;
    older_index_next  = older_index;
    newer_index_next  = newer_index;
    fill_count_next   = fill_count;
    odd_triangle_next = odd_triangle;
    emit  = 1'b0;
    tri_a = older_index;
    tri_b = newer_index;
    tri_c = item.index;
    priority if (fill_count == 2'd0) begin
      if (prim_mode == MODE_FAN) fan_anchor_next = item.index;
      else                       older_index_next = item.index;
      fill_count_next = 2'd1;
    end else if (fill_count == 2'd1) begin
      if (prim_mode == MODE_FAN) older_index_next = item.index;
      else                       newer_index_next = item.index;
      fill_count_next = 2'd2;
    end else begin
      emit = 1'b1;
      unique case (prim_mode)
        MODE_STRIP: begin
          if (odd_triangle) begin
            tri_b = item.index;
            tri_c = newer_index;
          end
          older_index_next  = newer_index;
          newer_index_next  = item.index;
          odd_triangle_next = !odd_triangle;
        end
        MODE_FAN: begin
          tri_b = item.index;
          tri_c = fan_anchor;
          older_index_next = item.index;
        end
        // list, and the unused code behaves as list
        default: begin
          fill_count_next = 2'd0;
        end
      endcase
    end
    // end of draw drops partial triangles
    if (item.last) begin
      fan_anchor_next   = '0;
      older_index_next  = '0;
      newer_index_next  = '0;
      fill_count_next   = 2'd0;
      odd_triangle_next = 1'b0;
    end
  end

  // assembly state
  always_ff @(posedge clk) begin
    if (rst) begin
      fan_anchor   <= '0;
      older_index  <= '0;
      newer_index  <= '0;
      fill_count   <= 2'd0;
      odd_triangle <= 1'b0;
    end else if (advance) begin
      fan_anchor   <= fan_anchor_next;
      older_index  <= older_index_next;
      newer_index  <= newer_index_next;
      fill_count   <= fill_count_next;
      odd_triangle <= odd_triangle_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_tdata <= {tri_c, tri_b, tri_a};
      m_tlast <= item.last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/triangle_strip_fan_to_list.sv
// Triangle strip/fan to list assembler, top level.
// A closing index request passes through the input register; its triangle is then held in the result register.
// Throughput: one index per cycle, set by the input register and the result register
// handing over in the same cycle; the master side stalling holds both stages.
// Reset (rst, synchronous): empties both stages, clears assembly state,
// mode returns to triangle list and base vertex to zero.
`default_nettype none

module triangle_strip_fan_to_list (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [15:0]                 s_tdata,  // [15:0] vertex_index
  input  wire logic                        s_tlast,  // last_index
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [47:0]                      m_tdata,  // [15:0] corner_a, [31:16] corner_b, [47:32] corner_c
  output logic                             m_tlast,  // final_triangle
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tsfl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import tsfl_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  advance;

  tsfl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tsfl_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .base_vertex (cfg.base_vertex),
    .advance     (advance),
    .item        (item)
  );

  tsfl_assemble u_asm (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .prim_mode (cfg.prim_mode),
    .advance   (advance),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/tsfl_checker.sv
// port-level checks for the assembler, bound to the top level
`default_nettype none

module tsfl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        m_tlast
);

  // a stalled triangle stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("triangle request dropped while stalled");

  // a stalled triangle keeps its corners and flag
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("triangle payload changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("triangle offered right after reset");

  // with nothing pending on the output the input side must be open
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty result register");

endmodule

bind triangle_strip_fan_to_list tsfl_checker u_tsfl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: bench/tb.sv
// self-checking testbench for the triangle strip/fan to list assembler
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsfl_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 390;

  typedef struct packed {
    idx_t a;
    idx_t b;
    idx_t c;
    logic fin;
  } triangle_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = '0;   // [15:0] vertex_index
  logic              s_tlast = 1'b0; // last_index
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [47:0]       m_tdata;        // [15:0] corner_a, [31:16] corner_b, [47:32] corner_c
  logic              m_tlast;        // final_triangle
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // predicted configuration and assembly state
  logic [1:0] cfg_mode = MODE_LIST;
  idx_t       cfg_base = '0;
  idx_t       fan_anchor = '0;
  idx_t       older_idx = '0;
  idx_t       newer_idx = '0;
  logic [1:0] fill_cnt = '0;
  logic       odd_tri = 1'b0;

  triangle_t pending_tris[$];
  triangle_t got_tri;
  int        mismatches = 0;
  int        cycle_count = 0;

  // idling controls: src_idle for the sender; sink_idle, sink_wait and hold_cycles for the receiver
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  int sink_wait = 0;
  int hold_cycles = 0;

  triangle_strip_fan_to_list dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stall after each triangle while sink_idle is set, plus long hold-offs on request
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      sink_wait = sink_idle ? $urandom_range(0, 19) : 0;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // checker: each triangle against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_tris.size() == 0) begin
        $display("%0t: triangle expected none actual %h final %b", $time, m_tdata, m_tlast);
        mismatches++;
      end else begin
        got_tri = pending_tris.pop_front();
        compare_field("corner_a", got_tri.a, m_tdata[15:0]);
        compare_field("corner_b", got_tri.b, m_tdata[31:16]);
        compare_field("corner_c", got_tri.c, m_tdata[47:32]);
        compare_field("final_triangle", {15'd0, got_tri.fin}, {15'd0, m_tlast});
      end
    end
  end

  // predicted assembly of one accepted index
  function automatic void assemble_index(input idx_t vi, input logic last);
    idx_t      r;
    triangle_t t;
    logic      emit;
    r = vi + cfg_base;
    emit = 1'b0;
    t = '0;
    if (fill_cnt == 2'd0) begin
      if (cfg_mode == MODE_FAN) fan_anchor = r;
      else older_idx = r;
      fill_cnt = 2'd1;
    end else if (fill_cnt == 2'd1) begin
      if (cfg_mode == MODE_FAN) older_idx = r;
      else newer_idx = r;
      fill_cnt = 2'd2;
    end else begin
      emit = 1'b1;
      t.fin = last;
      t.a = older_idx;
      if (cfg_mode == MODE_STRIP) begin
        // odd strip triangles swap the last two corners to keep the winding
        t.b = odd_tri ? r : newer_idx;
        t.c = odd_tri ? newer_idx : r;
        older_idx = newer_idx;
        newer_idx = r;
        odd_tri = ~odd_tri;
      end else if (cfg_mode == MODE_FAN) begin
        t.b = r;
        t.c = fan_anchor;
        older_idx = r;
      end else begin
        // list, and the unused mode code behaves the same
        t.b = newer_idx;
        t.c = r;
        fill_cnt = 2'd0;
      end
    end
    if (last) begin
      fan_anchor = '0;
      older_idx = '0;
      newer_idx = '0;
      fill_cnt = '0;
      odd_tri = 1'b0;
    end
    if (emit) pending_tris = {pending_tris, t};
  endfunction

  // offer one index request and wait for it to be taken
  task automatic send_index(input idx_t vi, input logic last);
    int gap;
    gap = src_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= vi;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    assemble_index(vi, last);
  endtask

  // stop sending and let every expected triangle drain
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_tris.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_PRIM_MODE) cfg_mode = value[1:0];
    else cfg_base = value[15:0];
  endtask

  // junk in the unused upper bits must be ignored
  task automatic set_mode(input logic [1:0] mode);
    logic [31:0] junk;
    junk = $urandom_range(0, 1) ? $urandom() : 32'd0;
    settle();
    write_reg(REG_PRIM_MODE, {junk[31:2], mode});
  endtask

  task automatic set_base(input idx_t base);
    logic [31:0] junk;
    junk = $urandom_range(0, 1) ? $urandom() : 32'd0;
    settle();
    write_reg(REG_BASE_VERTEX, {junk[31:16], base});
  endtask

  // list mode from reset values, then wraparound of the base offset
  task automatic test_list_extremes();
    send_index(16'h0000, 1'b0);
    send_index(16'hFFFF, 1'b0);
    send_index(16'h8000, 1'b0);
    set_base(16'hFFFF);
    send_index(16'hFFFF, 1'b0);
    send_index(16'h0000, 1'b0);
    send_index(16'h0001, 1'b1);
  endtask

  task automatic test_strip_winding();
    set_mode(MODE_STRIP);
    set_base(16'h0000);
    send_index(16'h0010, 1'b0);
    send_index(16'h0020, 1'b0);
    send_index(16'h0030, 1'b0);
    send_index(16'h0040, 1'b0);
    send_index(16'h0050, 1'b1);
  endtask

  task automatic test_fan();
    set_mode(MODE_FAN);
    set_base(16'h0001);
    send_index(16'h0100, 1'b0);
    send_index(16'h0200, 1'b0);
    send_index(16'h0300, 1'b0);
    send_index(16'hFFFF, 1'b0);
    send_index(16'h0500, 1'b1);
  endtask

  task automatic test_unused_mode();
    set_mode(MODE_UNUSED);
    send_index(16'h1111, 1'b0);
    send_index(16'h2222, 1'b0);
    send_index(16'h3333, 1'b1);
  endtask

  // draws that end before any triangle closes
  task automatic test_short_draw();
    set_mode(MODE_STRIP);
    send_index(16'hAAAA, 1'b0);
    send_index(16'h5555, 1'b1);
    set_mode(MODE_FAN);
    send_index(16'h7777, 1'b1);
  endtask

  // mode switch keeps the partly assembled triangle
  task automatic test_mode_change();
    send_index(16'h0100, 1'b0);
    send_index(16'h0200, 1'b0);
    set_mode(MODE_STRIP);
    send_index(16'h0300, 1'b0);
    set_mode(MODE_LIST);
    send_index(16'h0400, 1'b1);
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_backpressure();
    int i;
    set_mode(MODE_STRIP);
    src_idle = 1'b0;
    hold_cycles = 80;
    for (i = 0; i < 30; i++) send_index(16'($urandom()), i == 29);
    settle();
    src_idle = 1'b1;
  endtask

  // phases of random draws under random settings; some draws are left open
  // across a setting change, some carry stray last flags
  task automatic test_random_draws(input int target);
    int         sent;
    int         draws;
    int         len;
    int         d;
    int         i;
    bit         noisy;
    bit         leave_open;
    logic       last;
    idx_t       vi;
    idx_t       base;
    logic [1:0] mode;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(0, 5))
        0: base = 16'h0000;
        1: base = 16'hFFFF;
        default: base = 16'($urandom());
      endcase
      mode = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 3) != 0) set_mode(mode);
      if ($urandom_range(0, 2) != 0) set_base(base);
      src_idle = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      draws = $urandom_range(1, 4);
      for (d = 0; d < draws; d++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 15);
        noisy = $urandom_range(0, 6) == 0;
        leave_open = (d == draws - 1) && ($urandom_range(0, 4) == 0);
        for (i = 0; i < len; i++) begin
          if (noisy) last = $urandom_range(0, 3) == 0;
          else last = (i == len - 1) && !leave_open;
          case ($urandom_range(0, 7))
            0: vi = 16'h0000;
            1: vi = 16'hFFFF;
            2: vi = 16'($urandom_range(0, 15));
            default: vi = 16'($urandom());
          endcase
          send_index(vi, last);
          sent++;
        end
      end
    end
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_list_extremes();
    test_strip_winding();
    test_fan();
    test_unused_mode();
    test_short_draw();
    test_mode_change();
    test_backpressure();
    test_random_draws(RANDOM_ITEMS);
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
